FILE: hdl/rdt_pkg.sv
// Package for the reference-counted deduplication table.
// Holds the mode and status codes; no dependencies.
`default_nettype none
package rdt_pkg;
  typedef enum logic [2:0] {
    MODE_PEEK    = 3'd0,
    MODE_LOOKUP  = 3'd1,
    MODE_ADD     = 3'd2,
    MODE_REF     = 3'd3,
    MODE_RELEASE = 3'd4
  } mode_code_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_BAD       = 3'd5,
    ST_SATURATED = 3'd6
  } status_code_t;
endpackage
`default_nettype wire

FILE: hdl/refcounted_dedup_table.sv
// Top level of the reference-counted deduplication table.
// A handle request reads its slot; a release that frees an entry also walks the bucket chain
// to unlink it. A key request walks its bucket chain, and an insert then scans upward for the
// lowest free slot.
// One request at a time: busy stays high until the result strobe; results cannot be stalled.
// Reset (rst, synchronous) starts a clearing pass over all bucket heads and slots, busy high.
`default_nettype none
module refcounted_dedup_table import rdt_pkg::*; #(
  parameter int BUCKETS    = 256,
  parameter int ENTRIES    = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [2:0]  mode,
  input  wire  logic [63:0] key,
  input  wire  logic [9:0]  handle,
  output logic              done,
  output logic [2:0]        status,
  output logic [9:0]        entry_slot,
  output logic [15:0]       count_now,
  output logic [10:0]       live_entries
);
  localparam int SW = $clog2(ENTRIES);
  localparam int LW = SW + 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CLR_LEN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW = $clog2(CLR_LEN);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_WALK, S_WALKW, S_HIT,
    S_SCAN, S_SCANW, S_INS, S_HND, S_HNDW, S_UNL, S_UNLW, S_OUT
  } state_t;

  // Memories; a slot is free when its count is zero.
  logic [LW-1:0]         head_mem [BUCKETS];
  logic [LW-1:0]         link_mem [ENTRIES];
  logic [63:0]           key_mem  [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem  [ENTRIES];

  state_t                state;
  logic [CW-1:0]         clr;
  logic [2:0]            req_mode;
  logic [63:0]           req_key;
  logic [9:0]            req_handle;
  logic [BW-1:0]         bkt;
  logic [LW-1:0]         cur;
  logic [LW-1:0]         tgt_next;
  logic [LW-1:0]         steps;
  logic [LW-1:0]         held;
  logic [LW-1:0]         rd_head;
  logic [LW-1:0]         rd_link;
  logic [63:0]           rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [2:0]            res_status;
  logic [LW-1:0]         res_slot;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [SW-1:0]         rd_addr;
  logic [BW-1:0]         head_addr;

  function automatic logic [BW-1:0] bucket_of(input logic [63:0] k);
    return (BUCKETS > 1) ? BW'(k % 64'(BUCKETS)) : '0;
  endfunction

  assign rd_addr   = cur[SW-1:0];
  assign head_addr = bkt;

  // Registered memory reads at the current slot and bucket.
  always_ff @(posedge clk) begin
    rd_head <= head_mem[head_addr];
    rd_link <= link_mem[rd_addr];
    rd_key  <= key_mem[rd_addr];
    rd_cnt  <= cnt_mem[rd_addr];
  end

  // Sequencer with its memory writes and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      bkt   <= '0;
      held  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        // Clearing pass: empty every bucket head and free every slot.
        S_CLEAR: begin
          if (32'(clr) < BUCKETS) head_mem[clr[BW-1:0]] <= NIL;
          if (32'(clr) < ENTRIES) cnt_mem[clr[SW-1:0]] <= '0;
          clr <= clr + 1'b1;
          if (32'(clr) == CLR_LEN - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_mode   <= mode;
            req_key    <= key;
            req_handle <= handle;
            bkt        <= bucket_of(key);
            cur        <= LW'(handle);
            steps      <= '0;
            res_status <= ST_NOT_FOUND;
            res_slot   <= '0;
            res_cnt    <= '0;
            if (mode <= MODE_ADD) state <= S_HEAD;
            else if (mode == MODE_REF || mode == MODE_RELEASE) state <= S_HND;
            else state <= S_OUT;
          end
        end
        S_HEAD: state <= S_HEADW;
        S_HEADW: begin
          cur   <= rd_head;
          state <= S_WALK;
        end
        S_WALK: begin
          if (cur >= NIL || steps >= NIL) begin
            if (req_mode == MODE_ADD) begin
              cur <= '0;
              state <= S_SCAN;
            end else state <= S_OUT;
          end else state <= S_WALKW;
        end
        S_WALKW: begin
          if (req_mode == MODE_RELEASE) begin
            // Unlink walk: stop at the predecessor of the freed slot.
            if (rd_link == res_slot) begin
              link_mem[rd_addr] <= tgt_next;
              state <= S_OUT;
            end else begin
              cur   <= rd_link;
              steps <= steps + 1'b1;
              state <= S_WALK;
            end
          end else if (rd_cnt != '0 && rd_key == req_key) state <= S_HIT;
          else begin
            cur   <= rd_link;
            steps <= steps + 1'b1;
            state <= S_WALK;
          end
        end
        // Hit on a key: take a reference unless peeking or saturated.
        S_HIT: begin
          res_slot <= cur;
          res_cnt  <= rd_cnt;
          if (req_mode == MODE_PEEK) res_status <= ST_HIT;
          else if (rd_cnt >= CMAX) res_status <= ST_SATURATED;
          else begin
            res_status <= ST_HIT;
            res_cnt <= rd_cnt + 1'b1;
            cnt_mem[rd_addr] <= rd_cnt + 1'b1;
          end
          state <= S_OUT;
        end
        // Scan upward from slot 0 for the lowest free slot.
        S_SCAN: begin
          if (cur >= NIL) begin
            res_status <= ST_FULL;
            state <= S_OUT;
          end else state <= S_SCANW;
        end
        S_SCANW: begin
          if (rd_cnt == '0) state <= S_INS;
          else begin
            cur   <= cur + 1'b1;
            state <= S_SCAN;
          end
        end
        S_INS: begin
          key_mem[rd_addr]  <= req_key;
          cnt_mem[rd_addr]  <= COUNT_BITS'(1);
          link_mem[rd_addr] <= rd_head;
          head_mem[bkt]     <= cur;
          held       <= held + 1'b1;
          res_status <= ST_INSERTED;
          res_slot   <= cur;
          res_cnt    <= COUNT_BITS'(1);
          state      <= S_OUT;
        end
        S_HND: state <= S_HNDW;
        S_HNDW: begin
          res_slot <= LW'(req_handle);
          if (32'(req_handle) >= ENTRIES || rd_cnt == '0) begin
            res_status <= ST_BAD;
            state <= S_OUT;
          end else if (req_mode == MODE_REF) begin
            res_cnt <= rd_cnt;
            if (rd_cnt >= CMAX) res_status <= ST_SATURATED;
            else begin
              res_status <= ST_HIT;
              res_cnt <= rd_cnt + 1'b1;
              cnt_mem[rd_addr] <= rd_cnt + 1'b1;
            end
            state <= S_OUT;
          end else if (rd_cnt > COUNT_BITS'(1)) begin
            res_status <= ST_HIT;
            res_cnt <= rd_cnt - 1'b1;
            cnt_mem[rd_addr] <= rd_cnt - 1'b1;
            state <= S_OUT;
          end else begin
            // Count reaches zero: free the slot and unlink it from the bucket chain.
            cnt_mem[rd_addr] <= '0;
            res_status <= ST_REMOVED;
            tgt_next <= rd_link;
            bkt      <= bucket_of(rd_key);
            if (held != '0) held <= held - 1'b1;
            steps <= '0;
            state <= S_UNL;
          end
        end
        S_UNL: state <= S_UNLW;
        S_UNLW: begin
          if (rd_head == res_slot) begin
            head_mem[bkt] <= tgt_next;
            state <= S_OUT;
          end else begin
            cur   <= rd_head;
            state <= S_WALK;
            req_mode <= 3'(MODE_RELEASE);
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign status       = res_status;
  assign entry_slot   = 10'(res_slot);
  assign count_now    = 16'(res_cnt);
  assign live_entries = 11'(held);

`ifndef SYNTHESIS
  a_done_from_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_OUT) else $error("strobe without result state");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= NIL) else $error("live count beyond table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> busy) else $error("request not taken");
`endif
endmodule
`default_nettype wire
